### hw/rtl/pgw_pkg.sv
// shared types and constants for the two-level page walker
package pgw_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned LEN_W      = 3;
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 72;
    localparam int unsigned M_TDATA_W  = 32;
    localparam int unsigned OFFSET_W   = 12;
    localparam int unsigned INDEX_W    = 10;

    // register index as decoded from paddr[2]
    localparam logic REG_PAGING_ENABLE = 1'b0;
    localparam logic REG_PAGE_DIR_BASE = 1'b1;

    // input word selector
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_DATA    = 1'b1;

    typedef enum logic [2:0] {
        KIND_READ_PDE    = 3'd0,
        KIND_READ_PTE    = 3'd1,
        KIND_PHYS        = 3'd2,
        KIND_NOT_PRESENT = 3'd3,
        KIND_CROSSING    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_PDE  = 2'd1,
        PHASE_PTE  = 2'd2
    } phase_t;

    // what the front decided about one input word
    typedef enum logic [1:0] {
        OP_CROSS = 2'd0,
        OP_PHYS  = 2'd1,
        OP_WALK  = 2'd2,
        OP_DATA  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] vaddr;  // request address
        logic [ADDR_W-1:0] word;   // directory entry address or returned entry
    } entry_t;

endpackage

### hw/rtl/two_level_page_walker.sv
// top level of the two-level page walker
// Translates 32-bit virtual addresses through two-level 4 KiB paging. Each input word
// is either a translation request (s_tuser = 0) or a returned directory/table entry
// (s_tuser = 1); each produces at most one output word: a directory or table entry
// read request, a physical address, a not-present fault or a page-crossing fault.
// The caller fetches requested entries and feeds them back as data words. A request
// arriving mid-walk abandons the walk; a data word with no walk pending gives nothing.
// Throughput is one input word per cycle while m_tready stays high. An input word goes
// into the two-entry queue when it is accepted; the walk phase machine then pops it from
// the queue head and registers its result in the output register, which drives m_tvalid.
// While an output word waits on m_tready, the queue fills up to its two entries, then
// s_tready drops until the output drains.
// Registers (APB, byte address): 0x0 paging_enable (bit 0),
// 0x4 page_dir_base (bits 31:12 used); sampled when a request is accepted, so write
// them only while the block is idle.
module two_level_page_walker (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pgw_pkg::PADDR_W-1:0]     paddr,
    input  logic [pgw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pgw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pgw_pkg::S_TDATA_W-1:0]   s_tdata,  // virt_addr[31:0], access_len[34:32], mem_data[66:35], zero pad
    input  logic                            s_tuser,  // mode
    // output words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pgw_pkg::M_TDATA_W-1:0]   m_tdata,  // address
    output logic [2:0]                      m_tuser   // kind
);
    import pgw_pkg::*;

    entry_t front_entry;
    entry_t q_head;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;
    logic   push;

    // register accesses complete without wait states
    assign pready = 1'b1;

    // queue slot free means the front can take a word
    assign s_tready = ~q_full;
    assign push     = s_tvalid & s_tready;

    // classify the incoming word against the current registers
    pgw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .mode       (s_tuser),
        .virt_addr  (s_tdata[ADDR_W-1:0]),
        .access_len (s_tdata[ADDR_W+LEN_W-1:ADDR_W]),
        .mem_data   (s_tdata[2*ADDR_W+LEN_W-1:ADDR_W+LEN_W]),
        .entry      (front_entry)
    );

    // decouples input acceptance from output back-pressure
    pgw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // walk phase tracking and result register
    pgw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### hw/rtl/pgw_front.sv
// front end: configuration registers and classification of input words
module pgw_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pgw_pkg::PADDR_W-1:0]     paddr,
    input  logic [pgw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pgw_pkg::APB_DATA_W-1:0]  prdata,
    input  logic                            mode,
    input  logic [pgw_pkg::ADDR_W-1:0]      virt_addr,
    input  logic [pgw_pkg::LEN_W-1:0]       access_len,
    input  logic [pgw_pkg::ADDR_W-1:0]      mem_data,
    output pgw_pkg::entry_t                 entry
);
    import pgw_pkg::*;

    logic              paging_enable_reg;
    logic [ADDR_W-1:0] page_dir_base_reg;
    logic              cfg_wr;
    logic [LEN_W-1:0]  len_m1;
    logic [OFFSET_W:0] end_offset;
    logic              crossing;

    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paging_enable_reg <= 1'b0;
            page_dir_base_reg <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PAGE_DIR_BASE) begin
                page_dir_base_reg <= pwdata;
            end else begin
                paging_enable_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_PAGE_DIR_BASE) ? page_dir_base_reg
                                                    : {{(APB_DATA_W-1){1'b0}}, paging_enable_reg};

    // zero length counts as one byte; carry out of the offset means a crossing
    assign len_m1     = (access_len == '0) ? '0 : access_len - LEN_W'(1);
    assign end_offset = {1'b0, virt_addr[OFFSET_W-1:0]} + {{(OFFSET_W+1-LEN_W){1'b0}}, len_m1};
    assign crossing   = end_offset[OFFSET_W];

    always_comb begin
        entry.vaddr = virt_addr;
        entry.word  = {page_dir_base_reg[ADDR_W-1:OFFSET_W],
                       virt_addr[ADDR_W-1:ADDR_W-INDEX_W], 2'b00};
        if (mode == MODE_DATA) begin
            entry.op   = OP_DATA;
            entry.word = mem_data;
        end else if (crossing) begin
            entry.op = OP_CROSS;
        end else if (!paging_enable_reg) begin
            entry.op = OP_PHYS;
        end else begin
            entry.op = OP_WALK;
        end
    end

endmodule

### hw/rtl/pgw_queue.sv
// two-entry queue between front and back
module pgw_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pgw_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output pgw_pkg::entry_t head
);
    import pgw_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/pgw_back.sv
// back end: walk phase machine and output register
module pgw_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  pgw_pkg::entry_t               q_head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pgw_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [2:0]                    m_tuser
);
    import pgw_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [ADDR_W-1:0] held_vaddr_reg, held_vaddr_next;
    logic              m_valid_reg, m_valid_next;
    kind_t             kind_reg, kind_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              emit;

    // take the head whenever the output register is free or being drained
    assign q_pop = q_not_empty & (~m_valid_reg | m_tready);

    always_comb begin
        phase_next      = phase_reg;
        held_vaddr_next = held_vaddr_reg;
        emit            = 1'b0;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        if (q_pop) begin
            unique case (q_head.op)
                OP_CROSS: begin
                    phase_next = PHASE_IDLE;
                    emit       = 1'b1;
                    kind_next  = KIND_CROSSING;
                    addr_next  = q_head.vaddr;
                end
                OP_PHYS: begin
                    phase_next = PHASE_IDLE;
                    emit       = 1'b1;
                    kind_next  = KIND_PHYS;
                    addr_next  = q_head.vaddr;
                end
                OP_WALK: begin
                    phase_next      = PHASE_PDE;
                    held_vaddr_next = q_head.vaddr;
                    emit            = 1'b1;
                    kind_next       = KIND_READ_PDE;
                    addr_next       = q_head.word;
                end
                OP_DATA: begin
                    unique case (phase_reg)
                        PHASE_PDE: begin
                            emit = 1'b1;
                            if (!q_head.word[0]) begin
                                phase_next = PHASE_IDLE;
                                kind_next  = KIND_NOT_PRESENT;
                                addr_next  = held_vaddr_reg;
                            end else begin
                                phase_next = PHASE_PTE;
                                kind_next  = KIND_READ_PTE;
                                addr_next  = {q_head.word[ADDR_W-1:OFFSET_W],
                                              held_vaddr_reg[OFFSET_W+INDEX_W-1:OFFSET_W],
                                              2'b00};
                            end
                        end
                        PHASE_PTE: begin
                            emit       = 1'b1;
                            phase_next = PHASE_IDLE;
                            if (!q_head.word[0]) begin
                                kind_next = KIND_NOT_PRESENT;
                                addr_next = held_vaddr_reg;
                            end else begin
                                kind_next = KIND_PHYS;
                                addr_next = {q_head.word[ADDR_W-1:OFFSET_W],
                                             held_vaddr_reg[OFFSET_W-1:0]};
                            end
                        end
                        default: begin
                            // stray entry word with no walk in progress
                            phase_next = PHASE_IDLE;
                        end
                    endcase
                end
                default: begin
                    phase_next = PHASE_IDLE;
                end
            endcase
        end
        if (q_pop) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PHASE_IDLE;
            held_vaddr_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            held_vaddr_reg <= held_vaddr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        addr_reg <= addr_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = addr_reg;
    assign m_tuser  = kind_reg;

endmodule

### tb/walk_checker.sv
// checker for the page walker: predicts every result word and compares it with the output
module walk_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pgw_pkg::PADDR_W-1:0]    paddr,
    input  logic [pgw_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pgw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pgw_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [2:0]                     m_tuser,
    output int                             fail_count,
    output int                             pending_count,
    output int                             result_count
);
    import pgw_pkg::*;

    typedef struct {
        kind_t             kind;
        logic [ADDR_W-1:0] address;
    } xlat_word_t;

    xlat_word_t        expected_words[$];
    logic              paging_on = 1'b0;
    logic [ADDR_W-1:0] dir_base = '0;
    phase_t            walk_state = PHASE_IDLE;
    logic [ADDR_W-1:0] walk_vaddr = '0;
    int                errors = 0;
    int                checked = 0;

    task automatic expect_word(input kind_t kind, input logic [ADDR_W-1:0] address);
        xlat_word_t w;
        w.kind = kind;
        w.address = address;
        expected_words.push_back(w);
    endtask

    task automatic predict_translation(input logic mode, input logic [ADDR_W-1:0] va,
                                       input logic [LEN_W-1:0] len,
                                       input logic [ADDR_W-1:0] entry);
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] last_byte;
        span = (len == '0) ? 32'd1 : 32'(len);
        last_byte = va + span - 32'd1;
        if (mode == MODE_REQUEST) begin
            // a request always drops whatever walk was open
            walk_state = PHASE_IDLE;
            if (last_byte[31:12] != va[31:12]) begin
                expect_word(KIND_CROSSING, va);
            end else if (!paging_on) begin
                expect_word(KIND_PHYS, va);
            end else begin
                walk_vaddr = va;
                walk_state = PHASE_PDE;
                expect_word(KIND_READ_PDE, {dir_base[31:12], va[31:22], 2'b00});
            end
        end else begin
            case (walk_state)
                PHASE_PDE: begin
                    if (!entry[0]) begin
                        walk_state = PHASE_IDLE;
                        expect_word(KIND_NOT_PRESENT, walk_vaddr);
                    end else begin
                        walk_state = PHASE_PTE;
                        expect_word(KIND_READ_PTE, {entry[31:12], walk_vaddr[21:12], 2'b00});
                    end
                end
                PHASE_PTE: begin
                    walk_state = PHASE_IDLE;
                    if (!entry[0])
                        expect_word(KIND_NOT_PRESENT, walk_vaddr);
                    else
                        expect_word(KIND_PHYS, {entry[31:12], walk_vaddr[11:0]});
                end
                default: walk_state = PHASE_IDLE;
            endcase
        end
    endtask

    always @(posedge aclk) begin
        xlat_word_t want;
        if (!aresetn) begin
            paging_on = 1'b0;
            dir_base = '0;
            walk_state = PHASE_IDLE;
            walk_vaddr = '0;
            expected_words.delete();
        end else begin
            // output side first: a word accepted this edge cannot come out this edge
            if (m_tvalid && m_tready) begin
                checked++;
                if (expected_words.size() == 0) begin
                    $error("unexpected word: kind %0d address %h", m_tuser, m_tdata);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== want.address) begin
                        $error("address: expected %h, got %h", want.address, m_tdata);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_translation(s_tuser, s_tdata[31:0], s_tdata[34:32], s_tdata[66:35]);
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_PAGING_ENABLE)
                    paging_on = pwdata[0];
                else
                    dir_base = pwdata;
            end
        end
        fail_count    <= errors;
        pending_count <= expected_words.size();
        result_count  <= checked;
    end

endmodule

### tb/tb.sv
// testbench top for the two-level page walker: stimulus, receiver stalls and verdict
module tb;
    import pgw_pkg::*;

    // quiet cycles tolerated before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // extra cycles after the last expected word let ignored data words still in flight clear
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_WORDS   = 550;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_RUNS
    } ready_style_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;  // virt_addr, access_len, mem_data, zero pad
    logic                  s_tuser  = 1'b0; // mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // address
    logic [2:0]            m_tuser;        // kind

    int fail_count;
    int pending_count;
    int result_count;

    // sender bookkeeping
    int   words_sent    = 0;
    int   burst_left    = 0;
    int   settings_done = 0;
    logic paging_now    = 1'b0;  // what the generator believes paging_enable holds

    // receiver pattern state
    ready_style_t ready_style = READY_ALWAYS;
    int           style_left  = 0;
    int           run_left    = 0;

    int quiet_cycles = 0;

    always #4 aclk = ~aclk;

    two_level_page_walker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    walk_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    // receiver: switches between always ready, coin-flip ready and long on/off runs
    always @(posedge aclk) begin
        if (style_left == 0) begin
            ready_style = ready_style_t'($urandom_range(0, 2));
            style_left = $urandom_range(20, 120);
        end
        style_left--;
        case (ready_style)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                // hold the current level for a run, then flip it
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 12);
                    m_tready <= ~m_tready;
                end
                run_left--;
            end
        endcase
    end

    // watchdog: any accepted word on either channel counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one input word; bursts of random length, separated by gaps with valid low
    task automatic send_word(input logic mode, input logic [ADDR_W-1:0] va,
                             input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] entry);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            // now and then a long burst with no idle cycles at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, entry, len, va};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_request(input logic [ADDR_W-1:0] va, input logic [LEN_W-1:0] len);
        send_word(MODE_REQUEST, va, len, $urandom());
    endtask

    // returned entry; the address and length fields carry junk the block must ignore
    task automatic send_entry(input logic [ADDR_W-1:0] entry);
        send_word(MODE_DATA, $urandom(), LEN_W'($urandom_range(0, 7)), entry);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (idx == REG_PAGING_ENABLE)
            paging_now = value[0];
    endtask

    task automatic apply_settings(input logic paging, input logic [APB_DATA_W-1:0] base);
        write_reg(REG_PAGING_ENABLE, {31'b0, paging});
        write_reg(REG_PAGE_DIR_BASE, base);
        settings_done++;
    endtask

    // drain: no expected word left, then let ignored words clear the pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly in-page offsets, some hugging the page end, some near the top of memory
    function automatic logic [ADDR_W-1:0] pick_vaddr();
        logic [ADDR_W-1:0] va;
        va = $urandom();
        case ($urandom_range(0, 9))
            0: va[11:0] = 12'hfff - 12'($urandom_range(0, 7));
            1: va = 32'hffff_fff8 + 32'($urandom_range(0, 7));
            2: ;
            default: va[11:0] = 12'($urandom_range(0, 4088));
        endcase
        return va;
    endfunction

    // entry word, present bit set most of the time so walks get to the end
    function automatic logic [ADDR_W-1:0] entry_word();
        logic [ADDR_W-1:0] w;
        w = $urandom();
        w[0] = ($urandom_range(0, 7) != 0);
        return w;
    endfunction

    // one translation: request, directory entry, table entry, sometimes cut short
    task automatic random_walk();
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] pde;
        int                shape;
        len = LEN_W'($urandom_range(0, 7));
        shape = $urandom_range(0, 19);
        send_request(pick_vaddr(), len);
        // with paging off there is nothing to feed back
        if (!paging_now || shape == 0)
            return;
        pde = entry_word();
        send_entry(pde);
        if (shape == 1 || !pde[0])
            return;
        send_entry(entry_word());
    endtask

    initial begin
        int   random_goal;
        int   phase_end;
        logic walk_open;
        logic paging;
        logic [APB_DATA_W-1:0] base;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // paging off after reset: length and page-crossing corners
        send_request(32'h0000_0000, 3'd0);  // zero length counts as one byte
        send_request(32'h0000_0ffc, 3'd4);  // ends exactly at the page end
        send_request(32'h0000_0ffd, 3'd4);  // one byte over
        send_request(32'h1234_5ff9, 3'd7);  // long length, still inside
        send_request(32'h1234_5ffa, 3'd7);  // long length, crossing
        send_request(32'hffff_ffff, 3'd1);  // last byte of memory
        send_request(32'hffff_fffe, 3'd4);  // wraps past the top, counts as crossing
        send_entry(32'hffff_ffff);          // data with no walk open is dropped
        settle();

        apply_settings(1'b1, 32'hffff_ffff);
        // full walk with all-ones everywhere
        send_request(32'hffff_ffff, 3'd1);
        send_entry(32'hffff_ffff);
        send_entry(32'hffff_ffff);
        // directory entry not present
        send_request(32'h0000_0000, 3'd0);
        send_entry(32'h0000_0000);
        // table entry not present
        send_request(32'h0040_0000, 3'd2);
        send_entry(32'h0000_0001);
        send_entry(32'hffff_fffe);
        // second request abandons the first walk
        send_request(32'habcd_e123, 3'd4);
        send_request(32'h5555_5555, 3'd1);
        send_entry(32'haaaa_aaab);
        send_entry(32'h5555_5555);
        // crossing faults even with paging on, and leaves no walk behind
        send_request(32'h0000_0fff, 3'd2);
        send_entry(32'h0000_0001);
        // base changes while a walk is open: the walk keeps its old directory lookup
        send_request(32'h7fff_ffff, 3'd1);
        settle();
        apply_settings(1'b1, 32'h0000_0000);
        send_entry(32'h0000_0001);
        send_entry(32'h1234_5001);

        // random phases, each under its own register setting
        random_goal = words_sent + RANDOM_WORDS;
        walk_open = 1'b0;
        for (int phase = 0; words_sent < random_goal; phase++) begin
            settle();
            case (phase)
                0: begin
                    paging = 1'b1;
                    base = 32'h0000_0000;
                end
                1: begin
                    paging = 1'b0;
                    base = 32'hffff_ffff;
                end
                2: begin
                    paging = 1'b1;
                    base = 32'hffff_ffff;
                end
                default: begin
                    paging = ($urandom_range(0, 3) != 0);
                    base = $urandom();
                end
            endcase
            apply_settings(paging, base);
            // finish a walk that was started under the previous setting
            if (walk_open) begin
                send_entry(entry_word());
                send_entry(entry_word());
            end
            phase_end = words_sent + $urandom_range(50, 90);
            while (words_sent < phase_end && words_sent < random_goal) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(logic'($urandom_range(0, 1)), $urandom(),
                              LEN_W'($urandom_range(0, 7)), $urandom());
                else
                    random_walk();
            end
            // sometimes leave a walk open across the next register writes
            walk_open = paging_now && ($urandom_range(0, 1) == 1);
            if (walk_open)
                send_request(pick_vaddr(), LEN_W'($urandom_range(0, 4)));
        end

        settle();
        $display("covered %0d input words and %0d result words under %0d register settings",
                 words_sent, result_count, settings_done);
        $display("walks included crossings, pass-through, missing entries and abandoned walks");
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
